FILE: design/exlock_pkg.sv
// Shared types, constants and status codes for the exclusive lock block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package exlock_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ID_BITS_DEF     = 16;

    // Fixed width of the id fields on the ports
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;

    // Request opcodes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_ACQUIRED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_SHARED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_HANDOFF  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FREED    = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd6;

    // Input item
    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] process_id;
    } req_t;

    // Result item
    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  woken_id;
        logic [FIELD_W-1:0]  owner_id;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic commit;    // update lock state and load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } dp_stat_t;

endpackage

FILE: design/exclusive_lock_with_wait_fifo.sv
// Exclusive lock with FIFO wait queue: one request in, one result out.
// Request path: the input transfer captures the request, then the decide state commits it
// into the result register once that register is free; no new request is taken until then.
// The waiter ring read is registered, so the head entry is fetched during the capture cycle.
// Reset (rst_n, async low): lock free, queue empty, exclusive mode, no result pending.
// Depends on exlock_pkg, exlock_ctrl, exlock_dp.
`timescale 1ns / 1ps

module exclusive_lock_with_wait_fifo #(
    parameter int QUEUE_DEPTH = exlock_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = exlock_pkg::ID_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  exlock_pkg::req_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output exlock_pkg::rsp_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);
    import exlock_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Mode register takes a write in any cycle
    assign cfg_ready = 1'b1;

    exlock_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    exlock_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: design/exlock_ctrl.sv
// Controller for the exclusive lock: sequences capture and commit of one request.
// Depends on exlock_pkg.
`timescale 1ns / 1ps

module exlock_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  exlock_pkg::dp_stat_t stat,
    output exlock_pkg::dp_cmd_t  cmd
);
    import exlock_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_DECIDE = 1'b1;

    logic state_reg;
    logic state_next;

    // Handshake and commands
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        cmd.capture = in_valid && in_ready;
        cmd.commit  = (state_reg == S_DECIDE) && stat.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (cmd.commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: design/exlock_dp.sv
// Datapath for the exclusive lock: owner, waiter ring, mode and result register.
// Depends on exlock_pkg.
`timescale 1ns / 1ps

module exlock_dp #(
    parameter int QUEUE_DEPTH = exlock_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = exlock_pkg::ID_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  exlock_pkg::req_t     in_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  exlock_pkg::dp_cmd_t  cmd,
    output exlock_pkg::dp_stat_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output exlock_pkg::rsp_t     out_data
);
    import exlock_pkg::*;

    localparam int STORE_W = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // Mode and lock state
    logic               shared_reg;
    logic               busy_reg,  busy_next;
    logic [STORE_W-1:0] owner_reg, owner_next;
    logic [PTR_W-1:0]   head_reg,  head_next;
    logic [PTR_W-1:0]   tail_reg,  tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Captured request
    logic               op_reg;
    logic [STORE_W-1:0] pid_reg;

    // Waiter ring memory with registered read of the head entry
    logic [STORE_W-1:0] mem [QUEUE_DEPTH];
    logic [STORE_W-1:0] rd_data_reg;
    logic               mem_we;

    // Result register
    logic out_valid_reg, out_valid_next;
    rsp_t out_data_reg,  out_data_next;

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

    // Lock decision for the captured request
    always_comb
    begin
        busy_next              = busy_reg;
        owner_next             = owner_reg;
        head_next              = head_reg;
        tail_next              = tail_reg;
        count_next             = count_reg;
        mem_we                 = 1'b0;
        out_data_next.granted  = 1'b0;
        out_data_next.status   = STAT_IGNORED;
        out_data_next.woken_id = '0;
        if (op_reg == OP_ACQUIRE)
        begin
            if (shared_reg)
            begin
                out_data_next.granted = 1'b1;
                out_data_next.status  = STAT_SHARED;
            end
            else if (!busy_reg)
            begin
                busy_next             = 1'b1;
                owner_next            = pid_reg;
                out_data_next.granted = 1'b1;
                out_data_next.status  = STAT_ACQUIRED;
            end
            else if (count_reg != CNT_FULL)
            begin
                mem_we               = 1'b1;
                tail_next            = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                count_next           = count_reg + 1'b1;
                out_data_next.status = STAT_QUEUED;
            end
            else
            begin
                out_data_next.status = STAT_REJECTED;
            end
        end
        else
        begin
            if (shared_reg || !busy_reg)
            begin
                out_data_next.status = STAT_IGNORED;
            end
            else if (count_reg != '0)
            begin
                owner_next             = rd_data_reg;
                head_next              = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                count_next             = count_reg - 1'b1;
                out_data_next.woken_id = FIELD_W'(rd_data_reg);
                out_data_next.status   = STAT_HANDOFF;
            end
            else
            begin
                busy_next            = 1'b0;
                owner_next           = '0;
                out_data_next.status = STAT_FREED;
            end
        end
        out_data_next.owner_id = busy_next ? FIELD_W'(owner_next) : '0;
    end

    // Result valid: loads on commit, drops on a transfer
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shared_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            owner_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                shared_reg <= cfg_data;
            if (cmd.commit)
            begin
                busy_reg  <= busy_next;
                owner_reg <= owner_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data.opcode;
            pid_reg <= in_data.process_id[STORE_W-1:0];
        end
        if (cmd.commit)
            out_data_reg <= out_data_next;
    end

    // Waiter ring: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (cmd.commit && mem_we)
            mem[tail_reg] <= pid_reg;
        rd_data_reg <= mem[head_reg];
    end

endmodule

FILE: design/exlock_checker.sv
// Port-level checks for the exclusive lock, bound to the top level.
// Depends on exlock_pkg and exclusive_lock_with_wait_fifo.
`timescale 1ns / 1ps

module exlock_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input exlock_pkg::rsp_t out_data
);
    import exlock_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One request in flight: no back-to-back input transfers
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a request is in flight");

    // Grant flag matches the granting status codes
    a_grant_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.granted ==
            (out_data.status == STAT_ACQUIRED || out_data.status == STAT_SHARED)))
        else $error("granted flag disagrees with status");

    // Woken id only on handoff
    a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STAT_HANDOFF |-> out_data.woken_id == '0)
        else $error("woken id set without handoff");

    // Freed lock reports no owner
    a_freed_owner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STAT_FREED |-> out_data.owner_id == '0)
        else $error("owner reported after free");

endmodule

bind exclusive_lock_with_wait_fifo exlock_checker u_exlock_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: dv/exclusive_lock_with_wait_fifo_tb.sv
// Self-checking testbench for exclusive_lock_with_wait_fifo: a directed table, then random
// request traffic under random sender bursts and receiver stalls, checked by a lock model.
// Depends on exlock_pkg and the exclusive_lock_with_wait_fifo RTL.
`timescale 1ns / 1ps

module exclusive_lock_with_wait_fifo_tb;

    import exlock_pkg::*;

    localparam int RING_DEPTH   = QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        opcode;
        logic [15:0] pid;
        bit          typed;
        rsp_t        want;
    } stim_row_t;

    typedef struct {
        bit   typed;
        rsp_t want;
    } typed_answer_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    // Lock model state
    logic        mode_shared = 1'b0;
    logic        lock_busy   = 1'b0;
    logic [15:0] lock_owner  = '0;
    logic [15:0] wait_ring [RING_DEPTH];
    int          wait_head   = 0;
    int          wait_count  = 0;

    rsp_t          pending_results [$];
    typed_answer_t typed_answers [$];
    stim_row_t     directed_rows [$];
    int            fail_count = 0;
    int            idle_cycles = 0;
    bit            hold_req = 1'b0;

    // Monitor scratch
    rsp_t          mon_want;
    typed_answer_t mon_typed;

    exclusive_lock_with_wait_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Lock decision for one accepted request; updates the model state
    function automatic rsp_t predict_lock(req_t r);
        rsp_t res;
        res = '0;
        if (r.opcode == OP_ACQUIRE)
        begin
            if (mode_shared)
            begin
                res.granted = 1'b1;
                res.status  = STAT_SHARED;
            end
            else if (!lock_busy)
            begin
                lock_busy   = 1'b1;
                lock_owner  = r.process_id;
                res.granted = 1'b1;
                res.status  = STAT_ACQUIRED;
            end
            else if (wait_count < RING_DEPTH)
            begin
                wait_ring[(wait_head + wait_count) % RING_DEPTH] = r.process_id;
                wait_count = wait_count + 1;
                res.status = STAT_QUEUED;
            end
            else
                res.status = STAT_REJECTED;
        end
        else
        begin
            if (mode_shared || !lock_busy)
                res.status = STAT_IGNORED;
            else if (wait_count > 0)
            begin
                // oldest waiter takes over
                res.woken_id = wait_ring[wait_head];
                lock_owner   = wait_ring[wait_head];
                wait_head    = (wait_head + 1) % RING_DEPTH;
                wait_count   = wait_count - 1;
                res.status   = STAT_HANDOFF;
            end
            else
            begin
                lock_busy  = 1'b0;
                lock_owner = '0;
                res.status = STAT_FREED;
            end
        end
        res.owner_id = lock_busy ? lock_owner : '0;
        return res;
    endfunction

    function automatic void add_row(row_kind_t kind, logic opcode, logic [15:0] pid,
                                    bit typed, logic granted, logic [STATUS_W-1:0] status,
                                    logic [15:0] woken, logic [15:0] owner);
        stim_row_t row;
        row.kind          = kind;
        row.opcode        = opcode;
        row.pid           = pid;
        row.typed         = typed;
        row.want.granted  = granted;
        row.want.status   = status;
        row.want.woken_id = woken;
        row.want.owner_id = owner;
        directed_rows.push_back(row);
    endfunction

    // Id mix: extremes often, otherwise full range
    function automatic logic [15:0] random_pid();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 16'h0000;
        else if (pick == 1)
            return 16'hFFFF;
        else
            return 16'($urandom());
    endfunction

    // Offer one request and hold it until the transfer; returns at the next falling edge
    task automatic send_req(logic opcode, logic [15:0] pid, bit typed, rsp_t want);
        typed_answer_t ta;
        ta.typed = typed;
        ta.want  = want;
        typed_answers.push_back(ta);
        in_valid           <= 1'b1;
        in_data.opcode     <= opcode;
        in_data.process_id <= pid;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Mode change only once every result is back and the block has settled
    task automatic write_mode(logic shared);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= shared;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic      phase_modes [7];
        int        sent;
        int        style;
        int        burst;
        int        rel_pct;
        stim_row_t row;

        phase_modes = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;

        // release on free lock, first owner, fill the waiters, overflow
        add_row(ROW_REQ, OP_RELEASE, 16'h0000, 1, 1'b0, STAT_IGNORED,  16'h0, 16'h0000);
        add_row(ROW_REQ, OP_ACQUIRE, 16'hFFFF, 1, 1'b1, STAT_ACQUIRED, 16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h0000, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h0001, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h8000, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h5555, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'hAAAA, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h1234, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h7FFF, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'hFFFE, 1, 1'b0, STAT_QUEUED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h4321, 1, 1'b0, STAT_REJECTED, 16'h0, 16'hFFFF);
        // shared mode with an exclusive owner kept
        add_row(ROW_CFG, 1'b1, 16'h0, 0, 1'b0, STAT_ACQUIRED, 16'h0, 16'h0);
        add_row(ROW_REQ, OP_ACQUIRE, 16'h0BAD, 1, 1'b1, STAT_SHARED,   16'h0, 16'hFFFF);
        add_row(ROW_REQ, OP_RELEASE, 16'hFFFF, 1, 1'b0, STAT_IGNORED,  16'h0, 16'hFFFF);
        add_row(ROW_CFG, 1'b0, 16'h0, 0, 1'b0, STAT_ACQUIRED, 16'h0, 16'h0);
        // drain: first handoff goes to id 0, which reads like a free lock
        add_row(ROW_REQ, OP_RELEASE, 16'h0000, 1, 1'b0, STAT_HANDOFF,  16'h0, 16'h0000);
        repeat (7)
            add_row(ROW_REQ, OP_RELEASE, 16'($urandom()), 0, 1'b0, STAT_ACQUIRED, 16'h0, 16'h0);
        add_row(ROW_REQ, OP_RELEASE, 16'hFFFF, 1, 1'b0, STAT_FREED,    16'h0, 16'h0000);
        add_row(ROW_REQ, OP_RELEASE, 16'h0000, 1, 1'b0, STAT_IGNORED,  16'h0, 16'h0000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_mode(row.opcode);
            else
                send_req(row.opcode, row.pid, row.typed, row.want);
        end

        // Random phases; each starts from a drained block with a mode write from the phase list
        foreach (phase_modes[p])
        begin
            write_mode(phase_modes[p]);
            if (p == 0)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // fill, drain, balanced or noise
                style = $urandom_range(0, 3);
                case (style)
                    0: rel_pct = 15;
                    1: rel_pct = 75;
                    default: rel_pct = 50;
                endcase
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++)
                begin
                    send_req(($urandom_range(0, 99) < rel_pct) ? OP_RELEASE : OP_ACQUIRE,
                             (style == 3) ? 16'($urandom()) : random_pid(), 0, '0);
                    sent++;
                end
                if ($urandom_range(0, 9) >= 4)
                    pause_sender($urandom_range(1, 8));
            end
        end

        // Wind down
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("exclusive_lock_with_wait_fifo_tb passed");
        else
            $display("exclusive_lock_with_wait_fifo_tb failed");
        $finish;
    end

    // Receiver: stall level is redrawn at the end of each span, plus one long hold-off
    initial
    begin
        int stall_pct;
        int span;
        out_ready <= 1'b0;
        stall_pct = 0;
        span      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 30;
                        3: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                    span = 50;
                end
                span--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Monitor: model update on request and config transfers, check on result transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mode_shared = cfg_data;
            if (in_valid && in_ready)
            begin
                mon_want  = predict_lock(in_data);
                mon_typed = typed_answers.pop_front();
                if (mon_typed.typed)
                    mon_want = mon_typed.want;
                pending_results.push_back(mon_want);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result %p", out_data);
                    fail_count++;
                end
                else
                begin
                    mon_want = pending_results.pop_front();
                    if (out_data.granted !== mon_want.granted)
                    begin
                        $error("granted: expected %0d, got %0d",
                               mon_want.granted, out_data.granted);
                        fail_count++;
                    end
                    if (out_data.status !== mon_want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               mon_want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.woken_id !== mon_want.woken_id)
                    begin
                        $error("woken_id: expected %h, got %h",
                               mon_want.woken_id, out_data.woken_id);
                        fail_count++;
                    end
                    if (out_data.owner_id !== mon_want.owner_id)
                    begin
                        $error("owner_id: expected %h, got %h",
                               mon_want.owner_id, out_data.owner_id);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("exclusive_lock_with_wait_fifo_tb failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
